// File: rtl/sjf_pkg.sv
`default_nettype none

package sjf_pkg;

	// ready store geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// transaction field widths
	localparam int ID_W    = 16;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 32;
	localparam int EV_W    = 2;
	localparam int WAIT_W  = 5;

	// operation codes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// result event codes
	localparam logic [EV_W-1:0] EV_ACCEPT   = 2'd0;
	localparam logic [EV_W-1:0] EV_DROP     = 2'd1;
	localparam logic [EV_W-1:0] EV_IDLE     = 2'd2;
	localparam logic [EV_W-1:0] EV_DISPATCH = 2'd3;

	// write / clear request from the sequencer to the ready store
	typedef struct packed {
		logic               set;
		logic               clr;
		logic [IDX_W-1:0]   idx;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
	} sjf_wr_t;

	// registered read data coming back from the ready store
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic               valid;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
	} sjf_rd_t;

endpackage

`default_nettype wire

// File: rtl/sjf_store.sv
`default_nettype none

module sjf_store
	import sjf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sjf_wr_t          wr,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_idx,
	output sjf_rd_t               rd
);

	logic [ID_W-1:0]    id_mem    [QUEUE_DEPTH];
	logic [BURST_W-1:0] burst_mem [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] vld_q;

	logic               rd_en_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               rd_valid_s1;
	logic [ID_W-1:0]    rd_id_s1;
	logic [BURST_W-1:0] rd_burst_s1;

	// job slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.set) begin
			id_mem[wr.idx]    <= wr.id;
			burst_mem[wr.idx] <= wr.burst;
		end
		if (rd_en) begin
			rd_id_s1    <= id_mem[rd_idx];
			rd_burst_s1 <= burst_mem[rd_idx];
			rd_idx_s1   <= rd_idx;
		end
	end

	// occupancy bits and read strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rd_en_s1    <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr.set)
				vld_q[wr.idx] <= 1'b1;
			else if (wr.clr)
				vld_q[wr.idx] <= 1'b0;
			rd_en_s1 <= rd_en;
			if (rd_en)
				rd_valid_s1 <= vld_q[rd_idx];
		end
	end

	assign rd.en    = rd_en_s1;
	assign rd.idx   = rd_idx_s1;
	assign rd.valid = rd_valid_s1;
	assign rd.id    = rd_id_s1;
	assign rd.burst = rd_burst_s1;

endmodule

`default_nettype wire

// File: rtl/sjf_cmp.sv
`default_nettype none

module sjf_cmp
	import sjf_pkg::*;
(
	input  wire logic [BURST_W-1:0] cand_burst,
	input  wire logic [ID_W-1:0]    cand_id,
	input  wire logic [BURST_W-1:0] best_burst,
	input  wire logic [ID_W-1:0]    best_id,
	output logic                    less
);

	// shorter burst wins, equal burst goes to the smaller id
	always_comb begin
		less = (cand_burst < best_burst) ||
			((cand_burst == best_burst) && (cand_id < best_id));
	end

endmodule

`default_nettype wire

// File: rtl/sjf_nonpreemptive_scheduler_unit.sv
// Non-preemptive shortest-job-first dispatcher. Each input transaction is either a job
// arrival (operation 0) or one clock tick (operation 1), and each gives exactly one result
// transaction. A job that arrives while all QUEUE_DEPTH slots hold waiting jobs is dropped;
// a burst of zero is taken as one. A tick frees the CPU when the running job's finish time
// equals the current time, then, with the CPU idle, dispatches the waiting job with the
// smallest burst (smaller id on a tie, lower slot on a full tie) and advances time by one.
// Times wrap modulo 2^32. Timing: a stored arrival or a dispatching tick walks the ready
// store through its single read port, one slot per cycle, into one shared comparator; a
// dropped arrival or a tick without dispatch skips that walk. One item is worked on at a
// time; the result register frees the input side once the result has been loaded, so a
// result still held by result_stall adds its stalled cycles to the next item.
`default_nettype none

module sjf_nonpreemptive_scheduler_unit
	import sjf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               operation,
	input  wire logic [ID_W-1:0]    job_id,
	input  wire logic [BURST_W-1:0] burst_len,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [EV_W-1:0]         event_res,
	output logic [ID_W-1:0]         run_id,
	output logic [TIME_W-1:0]       start_time,
	output logic [TIME_W-1:0]       end_time,
	output logic [WAIT_W-1:0]       waiting_count
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic               op_q;
	logic [EV_W-1:0]    ev_q;
	logic [ID_W-1:0]    new_id_q;
	logic [BURST_W-1:0] new_burst_q;
	logic               best_vld_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [ID_W-1:0]    best_id_q;
	logic [BURST_W-1:0] best_burst_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  finish_q;
	logic               busy_q;
	logic               res_vld_q;
	logic [EV_W-1:0]    res_ev_q;
	logic [ID_W-1:0]    res_id_q;
	logic [TIME_W-1:0]  res_start_q;
	logic [TIME_W-1:0]  res_end_q;
	logic [WAIT_W-1:0]  res_wait_q;

	logic               in_fire;
	logic               out_free;
	logic               finish_go;
	logic               busy_nxt;
	logic [BURST_W-1:0] burst_eff;
	logic [TIME_W-1:0]  end_calc;
	logic [CNT_W-1:0]   cnt_nxt;
	logic               less;
	logic               take;
	sjf_wr_t            wr;
	sjf_rd_t            rd;

	assign in_fire   = item_valid && !item_stall;
	assign out_free  = !res_vld_q || !result_stall;
	assign finish_go = (state_q == ST_DONE) && out_free;
	assign busy_nxt  = busy_q && (finish_q != now_q);
	assign burst_eff = (burst_len == '0) ? BURST_W'(1) : burst_len;
	assign end_calc  = now_q + TIME_W'(best_burst_q);

	// ready store
	assign wr.set   = finish_go && (ev_q == EV_ACCEPT);
	assign wr.clr   = finish_go && (ev_q == EV_DISPATCH);
	assign wr.idx   = best_idx_q;
	assign wr.id    = new_id_q;
	assign wr.burst = new_burst_q;

	sjf_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_en  (state_q == ST_SCAN),
		.rd_idx (scan_idx_q),
		.rd     (rd)
	);

	// shared comparator
	sjf_cmp u_cmp (
		.cand_burst (rd.burst),
		.cand_id    (rd.id),
		.best_burst (best_burst_q),
		.best_id    (best_id_q),
		.less       (less)
	);

	// ticks keep the best waiting job, arrivals keep the first free slot
	always_comb begin
		if (op_q == OP_TICK)
			take = rd.en && rd.valid && (!best_vld_q || less);
		else
			take = rd.en && !rd.valid && !best_vld_q;
	end

	// waiting count after the current item
	always_comb begin
		case (ev_q)
			EV_ACCEPT:   cnt_nxt = cnt_q + CNT_W'(1);
			EV_DISPATCH: cnt_nxt = cnt_q - CNT_W'(1);
			default:     cnt_nxt = cnt_q;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			best_vld_q <= 1'b0;
			cnt_q      <= '0;
			now_q      <= '0;
			finish_q   <= '0;
			busy_q     <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (res_vld_q && !result_stall && !finish_go)
				res_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						scan_idx_q <= '0;
						best_vld_q <= 1'b0;
						if (operation == OP_ARRIVE) begin
							if (cnt_q == CNT_W'(QUEUE_DEPTH))
								state_q <= ST_DONE;
							else
								state_q <= ST_SCAN;
						end else begin
							busy_q <= busy_nxt;
							if (busy_nxt || (cnt_q == '0))
								state_q <= ST_DONE;
							else
								state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (take)
						best_vld_q <= 1'b1;
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_idx_q == IDX_W'(QUEUE_DEPTH - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (take)
						best_vld_q <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						res_vld_q <= 1'b1;
						cnt_q     <= cnt_nxt;
						if (op_q == OP_TICK)
							now_q <= now_q + TIME_W'(1);
						if (ev_q == EV_DISPATCH) begin
							finish_q <= end_calc;
							busy_q   <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and scan candidate
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q        <= operation;
			new_id_q    <= job_id;
			new_burst_q <= burst_eff;
			if (operation == OP_ARRIVE)
				ev_q <= (cnt_q == CNT_W'(QUEUE_DEPTH)) ? EV_DROP : EV_ACCEPT;
			else
				ev_q <= (busy_nxt || (cnt_q == '0)) ? EV_IDLE : EV_DISPATCH;
		end
		if (take) begin
			best_idx_q   <= rd.idx;
			best_id_q    <= rd.id;
			best_burst_q <= rd.burst;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish_go) begin
			res_ev_q   <= ev_q;
			res_wait_q <= WAIT_W'(cnt_nxt);
			if (ev_q == EV_DISPATCH) begin
				res_id_q    <= best_id_q;
				res_start_q <= now_q;
				res_end_q   <= end_calc;
			end else begin
				res_id_q    <= '0;
				res_start_q <= '0;
				res_end_q   <= '0;
			end
		end
	end

	assign item_stall    = (state_q != ST_IDLE);
	assign result_valid  = res_vld_q;
	assign event_res     = res_ev_q;
	assign run_id        = res_id_q;
	assign start_time    = res_start_q;
	assign end_time      = res_end_q;
	assign waiting_count = res_wait_q;

endmodule

`default_nettype wire

// File: rtl/sjf_chk.sv
`default_nettype none

module sjf_chk
	import sjf_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire logic               operation,
	input wire logic [ID_W-1:0]    job_id,
	input wire logic [BURST_W-1:0] burst_len,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic [EV_W-1:0]    event_res,
	input wire logic [ID_W-1:0]    run_id,
	input wire logic [TIME_W-1:0]  start_time,
	input wire logic [TIME_W-1:0]  end_time,
	input wire logic [WAIT_W-1:0]  waiting_count
);

	// a stalled input transaction keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(operation) &&
			$stable(job_id) && $stable(burst_len))
		else $error("stalled input payload changed");

	// a stalled result holds its event
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(event_res) &&
			$stable(waiting_count))
		else $error("stalled result changed");

	// one item at a time: the input side closes right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input accepted while an item is in work");

	// dispatch fields are zero unless a job was dispatched
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (event_res != EV_DISPATCH) |->
			(run_id == '0) && (start_time == '0) && (end_time == '0))
		else $error("dispatch fields set without dispatch");

	// every dispatched job runs for at least one tick
	a_burst_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (event_res == EV_DISPATCH) |-> (end_time != start_time))
		else $error("dispatched job has empty run");

endmodule

bind sjf_nonpreemptive_scheduler_unit sjf_chk u_sjf_chk (.*);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import sjf_pkg::*;

	// one scheduler result as it appears on the output ports
	typedef struct packed {
		logic [EV_W-1:0]   ev;
		logic [ID_W-1:0]   rid;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] en;
		logic [WAIT_W-1:0] wcnt;
	} sched_res_t;

	// directed row: one input transaction, repeated, with an optional hand-written result
	typedef struct packed {
		logic               op;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [7:0]         reps;
		logic               known;
		sched_res_t         res;
	} dir_row_t;

	// idling pattern of the two channels
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	localparam int N_DIR = 11;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic               operation;
	logic [ID_W-1:0]    job_id;
	logic [BURST_W-1:0] burst_len;
	logic               result_valid;
	logic               result_stall;
	logic [EV_W-1:0]    event_res;
	logic [ID_W-1:0]    run_id;
	logic [TIME_W-1:0]  start_time;
	logic [TIME_W-1:0]  end_time;
	logic [WAIT_W-1:0]  waiting_count;

	// scheduler state mirror
	logic [ID_W-1:0]    slot_id    [QUEUE_DEPTH];
	logic [BURST_W-1:0] slot_burst [QUEUE_DEPTH];
	logic               slot_used  [QUEUE_DEPTH];
	logic [TIME_W-1:0]  cur_time;
	logic               cpu_on;
	logic [TIME_W-1:0]  done_time;

	sched_res_t pending_results [$];
	int         mismatch_cnt = 0;
	pace_t      pace = PACE_BOTH;
	logic       hold_req = 1'b0;

	// directed transactions: zero burst, full ties, fill to the brim, drops
	dir_row_t dir_rows [N_DIR] = '{
		'{OP_TICK,   16'h0000, 16'h0000, 8'd1, 1'b1, '{EV_IDLE,   16'h0, 32'h0, 32'h0, 5'd0}},
		'{OP_ARRIVE, 16'hFFFF, 16'h0000, 8'd1, 1'b1, '{EV_ACCEPT, 16'h0, 32'h0, 32'h0, 5'd1}},
		'{OP_ARRIVE, 16'h0000, 16'h0003, 8'd1, 1'b1, '{EV_ACCEPT, 16'h0, 32'h0, 32'h0, 5'd2}},
		'{OP_TICK,   16'h1111, 16'h2222, 8'd1, 1'b0, '0},
		'{OP_ARRIVE, 16'h0005, 16'h0002, 8'd2, 1'b0, '0},
		'{OP_TICK,   16'h0000, 16'h0000, 8'd1, 1'b0, '0},
		'{OP_ARRIVE, 16'h8000, 16'h0010, 8'd7, 1'b0, '0},
		'{OP_ARRIVE, 16'h7FFF, 16'h0001, 8'd7, 1'b0, '0},
		'{OP_ARRIVE, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, '{EV_DROP, 16'h0, 32'h0, 32'h0, 5'd16}},
		'{OP_ARRIVE, 16'h0000, 16'h8000, 8'd1, 1'b1, '{EV_DROP, 16'h0, 32'h0, 32'h0, 5'd16}},
		'{OP_TICK,   16'hFFFF, 16'hFFFF, 8'd2, 1'b0, '0}
	};

	sjf_nonpreemptive_scheduler_unit u_top (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#12_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// number of jobs waiting in the mirrored store
	function automatic int waiting_jobs();
		int n;
		n = 0;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			if (slot_used[i])
				n++;
		return n;
	endfunction

	// advance the mirror by one transaction and return the result it gives
	function automatic sched_res_t schedule_step(input logic op, input logic [ID_W-1:0] id,
			input logic [BURST_W-1:0] burst);
		sched_res_t res;
		int pick;
		int slot;
		res = '0;
		pick = -1;
		slot = -1;
		if (op == OP_ARRIVE) begin
			// first free slot takes the job
			for (int i = 0; i < QUEUE_DEPTH; i++)
				if (!slot_used[i] && slot < 0)
					slot = i;
			if (slot >= 0) begin
				slot_id[slot] = id;
				slot_burst[slot] = (burst == '0) ? BURST_W'(1) : burst;
				slot_used[slot] = 1'b1;
				res.ev = EV_ACCEPT;
			end else begin
				res.ev = EV_DROP;
			end
		end else begin
			// free the cpu when the running job is due
			if (cpu_on && done_time == cur_time)
				cpu_on = 1'b0;
			// shortest burst, then smallest id, then lowest slot
			if (!cpu_on)
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (slot_used[i] && (pick < 0 || slot_burst[i] < slot_burst[pick] ||
							(slot_burst[i] == slot_burst[pick] && slot_id[i] < slot_id[pick])))
						pick = i;
			if (pick >= 0) begin
				done_time = cur_time + TIME_W'(slot_burst[pick]);
				cpu_on = 1'b1;
				slot_used[pick] = 1'b0;
				res.ev = EV_DISPATCH;
				res.rid = slot_id[pick];
				res.st = cur_time;
				res.en = done_time;
			end else begin
				res.ev = EV_IDLE;
			end
			cur_time = cur_time + 1;
		end
		res.wcnt = WAIT_W'(waiting_jobs());
		return res;
	endfunction

	// offer one transaction, wait for it to be taken, record what it should give
	task automatic send_item(input logic op, input logic [ID_W-1:0] id,
			input logic [BURST_W-1:0] burst, input logic known, input sched_res_t known_res);
		sched_res_t predicted;
		while ((pace == PACE_SEND_GAPS && $urandom_range(0, 99) < 68) ||
				(pace == PACE_BOTH && $urandom_range(0, 99) < 9)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		job_id <= id;
		burst_len <= burst;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predicted = schedule_step(op, id, burst);
		pending_results.push_back(known ? known_res : predicted);
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected 0x%0h got 0x%0h", fname, want, got);
			mismatch_cnt++;
		end
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= (pace == PACE_RECV_STALLS && $urandom_range(0, 99) < 68) ||
					(pace == PACE_BOTH && $urandom_range(0, 99) < 9);
			end
		end
	end

	// compare each result transaction with the oldest pending one
	always @(posedge clk) begin
		sched_res_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: event_res %0d", event_res);
				mismatch_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("event_res", 32'(want.ev), 32'(event_res));
				check_field("run_id", 32'(want.rid), 32'(run_id));
				check_field("start_time", want.st, start_time);
				check_field("end_time", want.en, end_time);
				check_field("waiting_count", 32'(want.wcnt), 32'(waiting_count));
			end
		end
	end

	// stimulus
	initial begin
		int n_items;
		int arr_pct;
		int roll;
		logic op;
		logic [ID_W-1:0] id;
		logic [BURST_W-1:0] burst;

		item_valid = 1'b0;
		operation = OP_ARRIVE;
		job_id = '0;
		burst_len = '0;
		arst_n = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			slot_id[i] = '0;
			slot_burst[i] = '0;
			slot_used[i] = 1'b0;
		end
		cur_time = '0;
		cpu_on = 1'b0;
		done_time = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < N_DIR; r++)
			repeat (dir_rows[r].reps)
				send_item(dir_rows[r].op, dir_rows[r].id, dir_rows[r].burst,
					dir_rows[r].known, dir_rows[r].res);

		// random traffic in segments, each with its own pace and arrival mix
		for (int seg = 0; seg < 16; seg++) begin
			pace = pace_t'(seg % 4);
			if (seg == 4)
				hold_req = 1'b1;
			case ($urandom_range(0, 2))
				0: arr_pct = 15;
				1: arr_pct = 40;
				default: arr_pct = 75;
			endcase
			n_items = $urandom_range(100, 140);
			for (int k = 0; k < n_items; k++) begin
				op = ($urandom_range(0, 99) < arr_pct) ? OP_ARRIVE : OP_TICK;
				id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
				roll = $urandom_range(0, 99);
				// short bursts keep jobs finishing; wide ones only hit a full store
				if (op == OP_TICK)
					burst = BURST_W'($urandom);
				else if (roll < 65)
					burst = BURST_W'($urandom_range(1, 3));
				else if (roll < 88)
					burst = BURST_W'($urandom_range(4, 16));
				else if (waiting_jobs() == QUEUE_DEPTH)
					burst = BURST_W'($urandom_range(1, 65535));
				else
					burst = BURST_W'($urandom_range(1, 40));
				send_item(op, id, burst, 1'b0, '0);
			end
		end

		// drain, then dispatch a job with a near-maximum burst
		pace = PACE_BOTH;
		while (waiting_jobs() != 0 || (cpu_on && done_time != cur_time))
			send_item(OP_TICK, ID_W'($urandom), BURST_W'($urandom), 1'b0, '0);
		send_item(OP_ARRIVE, 16'hA5A5, 16'hFFFF, 1'b0, '0);
		send_item(OP_ARRIVE, 16'h5A5A, 16'hFFFE, 1'b0, '0);
		send_item(OP_TICK, 16'h0000, 16'h0000, 1'b0, '0);
		send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b0, '0);
		item_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
